// ----- src/ssd_pkg.sv -----
`default_nettype none

package ssd_pkg;

  localparam int FIELD_W = 32;
  localparam int WIDTH_DEFAULT = 32;
  localparam int WIDE_W = 64;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_BUSY = 2'b10
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic den_zero;
  } status_t;

endpackage

`default_nettype wire

// ----- src/ssd_if.sv -----
`default_nettype none

interface ssd_in_if;
  logic                        valid;
  logic                        ready;
  logic [ssd_pkg::FIELD_W-1:0] dividend;
  logic [ssd_pkg::FIELD_W-1:0] divisor;

  modport source (output valid, dividend, divisor, input ready);
  modport sink (input valid, dividend, divisor, output ready);
endinterface

interface ssd_out_if;
  logic                        valid;
  logic                        ready;
  logic [ssd_pkg::FIELD_W-1:0] quotient;
  logic [ssd_pkg::FIELD_W-1:0] remainder;
  logic                        divide_by_zero;

  modport source (output valid, quotient, remainder, divide_by_zero, input ready);
  modport sink (input valid, quotient, remainder, divide_by_zero, output ready);
endinterface

`default_nettype wire

// ----- src/shift_subtract_divider_top.sv -----
`default_nettype none

// Channel   Role   Handshake        Payload
// request   sink   valid / ready    dividend, divisor
// result    source valid / ready    quotient, remainder, divide_by_zero
//
// A nonzero divisor takes a transfer and then WIDTH steps of the single
// shift-subtract unit, one quotient bit per step.
// A zero divisor takes no steps; it finishes from the busy state.
// Reset is synchronous and clears the controller and the result valid flag.
// The result sits in an output register; a new request transfer is taken while
// it waits, and the last step, or a zero-divisor finish, stalls until it is free.

module shift_subtract_divider_top #(
  parameter int WIDTH = ssd_pkg::WIDTH_DEFAULT
) (
  input wire logic clk,
  input wire logic rst,
  ssd_in_if.sink   request,
  ssd_out_if.source result
);

  ssd_pkg::cmd_t    cmd;
  ssd_pkg::status_t status;

  ssd_ctrl #(
    .WIDTH (WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (request.valid),
    .in_ready  (request.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .status    (status),
    .cmd       (cmd)
  );

  ssd_datapath #(
    .WIDTH (WIDTH)
  ) u_datapath (
    .clk            (clk),
    .cmd            (cmd),
    .dividend       (request.dividend),
    .divisor        (request.divisor),
    .status         (status),
    .quotient       (result.quotient),
    .remainder      (result.remainder),
    .divide_by_zero (result.divide_by_zero)
  );

  a_busy_after_transfer : assert property (
    @(posedge clk) disable iff (rst)
    (request.valid && request.ready) |=> !request.ready
  ) else $error("request ready while a division is in progress");

  a_zero_quotient : assert property (
    @(posedge clk) disable iff (rst)
    (result.valid && result.divide_by_zero) |-> (result.quotient == '0)
  ) else $error("nonzero quotient on a zero divisor");

  a_result_from_busy : assert property (
    @(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(!request.ready)
  ) else $error("result appeared without a division in progress");

  a_step_needs_work : assert property (
    @(posedge clk) disable iff (rst)
    (cmd.step || cmd.finish) |-> !request.ready
  ) else $error("datapath command while idle");

endmodule

`default_nettype wire

// ----- src/ssd_ctrl.sv -----
`default_nettype none

module ssd_ctrl #(
  parameter int WIDTH = ssd_pkg::WIDTH_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  input  wire ssd_pkg::status_t status,
  output ssd_pkg::cmd_t         cmd
);

  localparam int CNT_W = $clog2(WIDTH);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(WIDTH - 1);

  ssd_pkg::state_t  state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic             out_valid_next;
  logic             slot_free;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == ssd_pkg::ST_IDLE);

  always_comb begin
    state_next = state;
    count_next = count;
    cmd        = '0;
    cmd.load   = in_valid && in_ready;
    unique case (state)
      ssd_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = ssd_pkg::ST_BUSY;
          count_next = '0;
        end
      end
      ssd_pkg::ST_BUSY: begin
        if (status.den_zero) begin
          if (slot_free) begin
            cmd.finish = 1'b1;
            state_next = ssd_pkg::ST_IDLE;
          end
        end else if (count == LAST) begin
          if (slot_free) begin
            cmd.step   = 1'b1;
            cmd.finish = 1'b1;
            state_next = ssd_pkg::ST_IDLE;
          end
        end else begin
          cmd.step   = 1'b1;
          count_next = count + 1'b1;
        end
      end
      default: begin
        state_next = ssd_pkg::ST_IDLE;
      end
    endcase
    if (cmd.finish) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ssd_pkg::ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

// ----- src/ssd_datapath.sv -----
`default_nettype none

module ssd_datapath #(
  parameter int WIDTH = ssd_pkg::WIDTH_DEFAULT
) (
  input  wire logic                        clk,
  input  wire ssd_pkg::cmd_t               cmd,
  input  wire logic [ssd_pkg::FIELD_W-1:0] dividend,
  input  wire logic [ssd_pkg::FIELD_W-1:0] divisor,
  output ssd_pkg::status_t                 status,
  output logic [ssd_pkg::FIELD_W-1:0]      quotient,
  output logic [ssd_pkg::FIELD_W-1:0]      remainder,
  output logic                             divide_by_zero
);

  logic [ssd_pkg::WIDE_W-1:0] dividend_wide, divisor_wide;
  logic [ssd_pkg::WIDE_W-1:0] quo_wide, rem_wide, num_wide;
  logic [WIDTH-1:0] num_in, den_in;
  logic [WIDTH-1:0] rem, quo, den;
  logic [WIDTH-1:0] rem_next, quo_next;
  logic [WIDTH-1:0] rem_final, quo_final;
  logic [WIDTH:0]   shifted, diff;
  logic             ge;
  logic             den_zero;

  assign dividend_wide = ssd_pkg::WIDE_W'(dividend);
  assign divisor_wide  = ssd_pkg::WIDE_W'(divisor);
  assign num_in        = dividend_wide[WIDTH-1:0];
  assign den_in        = divisor_wide[WIDTH-1:0];

  // The quotient register starts out holding the dividend; its top bit
  // moves into the partial remainder while quotient bits enter at the bottom.
  assign shifted  = {rem, quo[WIDTH-1]};
  assign diff     = shifted - {1'b0, den};
  assign ge       = (shifted >= {1'b0, den});
  assign rem_next = ge ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
  assign quo_next = {quo[WIDTH-2:0], ge};

  assign rem_final = cmd.step ? rem_next : rem;
  assign quo_final = cmd.step ? quo_next : quo;

  assign quo_wide = ssd_pkg::WIDE_W'(quo_final);
  assign rem_wide = ssd_pkg::WIDE_W'(rem_final);
  assign num_wide = ssd_pkg::WIDE_W'(quo);

  assign status.den_zero = den_zero;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem      <= '0;
      quo      <= num_in;
      den      <= den_in;
      den_zero <= (den_in == '0);
    end else if (cmd.step) begin
      rem <= rem_next;
      quo <= quo_next;
    end
    if (cmd.finish) begin
      divide_by_zero <= den_zero;
      if (den_zero) begin
        quotient  <= '0;
        remainder <= num_wide[ssd_pkg::FIELD_W-1:0];
      end else begin
        quotient  <= quo_wide[ssd_pkg::FIELD_W-1:0];
        remainder <= rem_wide[ssd_pkg::FIELD_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`default_nettype none

module tb;

  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 2 * (ssd_pkg::FIELD_W + 1);
  localparam int RANDOM_ITEMS = 1530;
  localparam int DIRECTED_COUNT = 22;

  typedef logic [ssd_pkg::FIELD_W-1:0] word_t;

  typedef struct packed {
    word_t quotient;
    word_t remainder;
    logic  divide_by_zero;
  } div_result_t;

  typedef struct packed {
    word_t dividend;
    word_t divisor;
    logic  has_expected;
    word_t quotient;
    word_t remainder;
    logic  divide_by_zero;
  } div_row_t;

  // Rows without a typed result are checked against the predictor.
  localparam div_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    '{32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000, 32'h0000_0000, 1'b1},
    '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1},
    '{32'h1234_5678, 32'h0000_0000, 1'b1, 32'h0000_0000, 32'h1234_5678, 1'b1},
    '{32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0},
    '{32'h0000_0000, 32'h0000_0001, 1'b1, 32'h0000_0000, 32'h0000_0000, 1'b0},
    '{32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 32'h0000_0000, 1'b0},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0001, 32'h0000_0000, 1'b0},
    '{32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 32'hFFFF_FFFE, 1'b0},
    '{32'hFFFF_FFFF, 32'h8000_0000, 1'b1, 32'h0000_0001, 32'h7FFF_FFFF, 1'b0},
    '{32'h8000_0000, 32'h8000_0000, 1'b1, 32'h0000_0001, 32'h0000_0000, 1'b0},
    '{32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0},
    '{32'h8000_0000, 32'h0000_0001, 1'b1, 32'h8000_0000, 32'h0000_0000, 1'b0},
    '{32'hFFFF_FFFF, 32'h0000_0002, 1'b1, 32'h7FFF_FFFF, 32'h0000_0001, 1'b0},
    '{32'h0000_0001, 32'h0000_0001, 1'b1, 32'h0000_0001, 32'h0000_0000, 1'b0},
    '{32'h0000_0064, 32'h0000_0007, 1'b0, 32'h0, 32'h0, 1'b0},
    '{32'hFFFF_FFFF, 32'h0000_0003, 1'b0, 32'h0, 32'h0, 1'b0},
    '{32'hDEAD_BEEF, 32'h0001_0001, 1'b0, 32'h0, 32'h0, 1'b0},
    '{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 32'h0, 32'h0, 1'b0},
    '{32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 32'h0, 32'h0, 1'b0},
    '{32'hFFFF_FFFF, 32'hC000_0001, 1'b0, 32'h0, 32'h0, 1'b0},
    '{32'h8000_0001, 32'h7FFF_FFFF, 1'b0, 32'h0, 32'h0, 1'b0},
    '{32'h0000_FFFF, 32'hFFFF_0000, 1'b0, 32'h0, 32'h0, 1'b0}
  };

  logic clk;
  logic rst;

  ssd_in_if  request_ch ();
  ssd_out_if result_ch ();

  shift_subtract_divider_top uut (
    .clk     (clk),
    .rst     (rst),
    .request (request_ch),
    .result  (result_ch)
  );

  div_result_t pending_results [$];
  int failures = 0;
  int requests_sent = 0;
  int zero_divisors = 0;
  int results_checked = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  int sink_cycles = 0;
  bit sink_steady = 1'b0;

  function automatic div_result_t predict_division(word_t dvd, word_t dvs);
    div_result_t res;
    if (dvs == '0) begin
      res.quotient = '0;
      res.remainder = dvd;
      res.divide_by_zero = 1'b1;
    end else begin
      res.quotient = dvd / dvs;
      res.remainder = dvd % dvs;
      res.divide_by_zero = 1'b0;
    end
    return res;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) begin
      return 0;
    end else if (roll < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 60);
  endfunction

  task automatic issue_division(input word_t dvd, input word_t dvs, input div_result_t want);
    request_ch.valid <= 1'b1;
    request_ch.dividend <= dvd;
    request_ch.divisor <= dvs;
    @(posedge clk);
    while (!request_ch.ready) @(posedge clk);
    pending_results.push_back(want);
    requests_sent++;
    if (dvs == '0) begin
      zero_divisors++;
    end
  endtask

  task automatic idle_request(input bit steady);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      request_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    div_row_t row;
    div_result_t want;
    word_t dvd;
    word_t dvs;
    bit steady;
    rst <= 1'b1;
    request_ch.valid <= 1'b0;
    request_ch.dividend <= '0;
    request_ch.divisor <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      row = DIRECTED_ROWS[i];
      if (row.has_expected) begin
        want = '{row.quotient, row.remainder, row.divide_by_zero};
      end else begin
        want = predict_division(row.dividend, row.divisor);
      end
      idle_request(1'b0);
      issue_division(row.dividend, row.divisor, want);
    end

    steady = 1'b0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 100 == 0) begin
        steady = ($urandom_range(0, 3) == 0);
      end
      dvd = $urandom;
      case ($urandom_range(0, 9))
        0: dvs = '0;
        1: dvs = $urandom_range(1, 15);
        2: dvs = $urandom | 32'h8000_0000;
        3: dvs = dvd + $urandom_range(0, 2);
        4: begin
          dvd = $urandom >> $urandom_range(0, 31);
          dvs = $urandom >> $urandom_range(0, 31);
        end
        5: dvs = $urandom >> $urandom_range(16, 31);
        default: dvs = $urandom;
      endcase
      idle_request(steady);
      issue_division(dvd, dvs, predict_division(dvd, dvs));
    end
    request_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d divisions, %0d of them by zero, and checked %0d results.",
             requests_sent, zero_divisors, results_checked);
    $display("Operands covered the field extremes, top-bit divisors and random bit widths.");
    if (failures == 0 && pending_results.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  always @(posedge clk) begin : result_check
    div_result_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        results_checked++;
        if (pending_results.size() == 0) begin
          $display("%0t: result transfer with nothing expected: q %h r %h z %b", $time,
                   result_ch.quotient, result_ch.remainder, result_ch.divide_by_zero);
          failures++;
        end else begin
          want = pending_results.pop_front();
          if (result_ch.quotient !== want.quotient) begin
            $display("%0t: quotient expected %h, got %h", $time,
                     want.quotient, result_ch.quotient);
            failures++;
          end
          if (result_ch.remainder !== want.remainder) begin
            $display("%0t: remainder expected %h, got %h", $time,
                     want.remainder, result_ch.remainder);
            failures++;
          end
          if (result_ch.divide_by_zero !== want.divide_by_zero) begin
            $display("%0t: divide_by_zero expected %b, got %b", $time,
                     want.divide_by_zero, result_ch.divide_by_zero);
            failures++;
          end
        end
      end

      sink_cycles++;
      if (sink_cycles % 400 == 0) begin
        sink_steady = ($urandom_range(0, 2) == 0);
      end
      if (stall_left > 0) begin
        stall_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
        if (!sink_steady && $urandom_range(0, 3) == 0) begin
          stall_left = pick_gap();
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (request_ch.valid && request_ch.ready) ||
        (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding", $time,
               idle_cycles, pending_results.size());
      $display("tb failed");
      $finish;
    end
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
src/ssd_pkg.sv
src/ssd_if.sv
src/ssd_ctrl.sv
src/ssd_datapath.sv
src/shift_subtract_divider_top.sv
tb/tb.sv
